// File: sv/circuit_label_swap_table_core_defines.svh
// Assertion macros used by the checker file of the label swap table.
`ifndef CIRCUIT_LABEL_SWAP_TABLE_CORE_DEFINES_SVH
`define CIRCUIT_LABEL_SWAP_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define CLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define CLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/cls_pkg.sv
// Package with the types, codes and defaults of the label swap table.
package cls_pkg;

	localparam int TABLE_ENTRIES_DEF = 8;
	localparam int ID_W              = 16;

	// Input item kinds.
	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_ROUTE   = 2'd1;
	localparam logic [1:0] KIND_DESTROY = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	// Result actions.
	localparam logic [2:0] ACT_NEXT            = 3'd0;
	localparam logic [2:0] ACT_PREV            = 3'd1;
	localparam logic [2:0] ACT_LOCAL           = 3'd2;
	localparam logic [2:0] ACT_INSERTED        = 3'd3;
	localparam logic [2:0] ACT_FULL            = 3'd4;
	localparam logic [2:0] ACT_DESTROY_FWD     = 3'd5;
	localparam logic [2:0] ACT_DESTROY_UNKNOWN = 3'd6;

	// One forwarding entry as stored in the table memory.
	typedef struct packed {
		logic [ID_W-1:0] prev_circ;
		logic [ID_W-1:0] prev_node;
		logic [ID_W-1:0] next_circ;
		logic [ID_W-1:0] next_node;
	} entry_t;

	// Flags produced by the shared compare unit for one scanned entry.
	typedef struct packed {
		logic prev_hit;
		logic node_ok;
		logic next_hit;
		logic free;
	} cmp_res_t;

endpackage

// File: sv/cls_cmp.sv
// Shared compare unit: matches one scanned table entry against the item's keys.
module cls_cmp (
	input  cls_pkg::entry_t           entry,
	input  logic                      entry_valid,
	input  logic [cls_pkg::ID_W-1:0]  key_circ,
	input  logic [cls_pkg::ID_W-1:0]  key_src,
	output cls_pkg::cmp_res_t         res
);
	import cls_pkg::*;

	// Empty slots never match; they only count as free.
	always_comb begin
		res.prev_hit = entry_valid && (entry.prev_circ == key_circ);
		res.node_ok  = (entry.prev_node == key_src);
		res.next_hit = entry_valid && (entry.next_circ == key_circ);
		res.free     = !entry_valid;
	end

endmodule

// File: sv/cls_store.sv
// Forwarding table storage: entry memory with a registered read port and valid flags.
module cls_store #(
	parameter int TABLE_ENTRIES = cls_pkg::TABLE_ENTRIES_DEF,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output cls_pkg::entry_t       rd_data,
	input  logic [IDX_W-1:0]      chk_idx,
	output logic                  chk_valid,
	input  logic                  wr_en,
	input  logic                  clr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  cls_pkg::entry_t       wr_data
);
	import cls_pkg::*;

	entry_t                   mem [TABLE_ENTRIES];
	entry_t                   rd_data_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Valid flags are cleared at once by reset, so the memory needs no clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (clr_en) begin
			valid_q[wr_addr] <= 1'b0;
		end
	end

	assign rd_data   = rd_data_q;
	assign chk_valid = valid_q[chk_idx];

endmodule

// File: sv/cls_ctrl.sv
// Sequencer: scans the table once per item of kinds 0 to 2, keeps the first hits and forms the result.
module cls_ctrl #(
	parameter int TABLE_ENTRIES = cls_pkg::TABLE_ENTRIES_DEF,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [63:0]               s_tdata,
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata,
	output logic [2:0]                m_tuser,
	input  logic [cls_pkg::ID_W-1:0]  own_node_id,
	output logic                      rd_en,
	output logic [IDX_W-1:0]          rd_addr,
	input  cls_pkg::entry_t           rd_data,
	output logic [IDX_W-1:0]          chk_idx,
	input  cls_pkg::cmp_res_t         cmp_res,
	output logic [cls_pkg::ID_W-1:0]  key_circ,
	output logic [cls_pkg::ID_W-1:0]  key_src,
	output logic                      wr_en,
	output logic                      clr_en,
	output logic [IDX_W-1:0]          wr_addr,
	output cls_pkg::entry_t           wr_data
);
	import cls_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              chk_q;
	logic [IDX_W-1:0]  chk_idx_q;

	// Item held for the whole scan.
	logic [1:0]        kind_q;
	logic [ID_W-1:0]   circ_q;
	logic [ID_W-1:0]   src_q;
	logic [ID_W-1:0]   ncirc_q;
	logic [ID_W-1:0]   nnode_q;

	// First hits found so far.
	logic              fwd_found_q;
	logic              fwd_node_ok_q;
	logic [IDX_W-1:0]  fwd_idx_q;
	logic [ID_W-1:0]   fwd_circ_q;
	logic [ID_W-1:0]   fwd_node_q;
	logic              rev_found_q;
	logic [ID_W-1:0]   rev_circ_q;
	logic [ID_W-1:0]   rev_node_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	// Output register.
	logic              m_tvalid_q;
	logic [2:0]        act_q;
	logic [ID_W-1:0]   oc_q;
	logic [ID_W-1:0]   od_q;
	logic [ID_W-1:0]   os_q;

	logic              in_xfer;
	logic              out_free;
	logic              finish;
	logic [2:0]        res_act;
	logic [ID_W-1:0]   res_c;
	logic [ID_W-1:0]   res_d;
	logic [ID_W-1:0]   res_s;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == ST_FINISH) && out_free;

	// Memory read address follows the scan counter; the compare works on that slot in the next cycle.
	assign rd_en    = (state_q == ST_SCAN);
	assign rd_addr  = cnt_q;
	assign chk_idx  = chk_idx_q;
	assign key_circ = circ_q;
	assign key_src  = src_q;

	// Result selection from the hits gathered during the scan.
	always_comb begin
		res_act = ACT_LOCAL;
		res_c   = '0;
		res_d   = '0;
		res_s   = own_node_id;
		case (kind_q)
			KIND_INSERT: begin
				res_act = free_found_q ? ACT_INSERTED : ACT_FULL;
				res_s   = '0;
			end
			KIND_ROUTE: begin
				if (fwd_found_q && fwd_node_ok_q) begin
					res_act = ACT_NEXT;
					res_c   = fwd_circ_q;
					res_d   = fwd_node_q;
				end else if (rev_found_q) begin
					res_act = ACT_PREV;
					res_c   = rev_circ_q;
					res_d   = rev_node_q;
				end else begin
					res_act = ACT_LOCAL;
					res_c   = circ_q;
					res_d   = own_node_id;
				end
			end
			KIND_DESTROY: begin
				if (fwd_found_q) begin
					res_act = ACT_DESTROY_FWD;
					res_c   = fwd_circ_q;
					res_d   = fwd_node_q;
				end else begin
					res_act = ACT_DESTROY_UNKNOWN;
				end
			end
			default: begin
				res_act = ACT_LOCAL;
			end
		endcase
	end

	// Table update in the finishing cycle: insert fills the free slot, destroy frees the hit.
	assign wr_en   = finish && (kind_q == KIND_INSERT) && free_found_q;
	assign clr_en  = finish && (kind_q == KIND_DESTROY) && fwd_found_q;
	assign wr_addr = (kind_q == KIND_INSERT) ? free_idx_q : fwd_idx_q;
	assign wr_data = '{prev_circ: circ_q, prev_node: src_q,
		next_circ: ncirc_q, next_node: nnode_q};

	// State, scan bookkeeping and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			chk_q         <= 1'b0;
			chk_idx_q     <= '0;
			kind_q        <= KIND_INSERT;
			circ_q        <= '0;
			src_q         <= '0;
			ncirc_q       <= '0;
			nnode_q       <= '0;
			fwd_found_q   <= 1'b0;
			fwd_node_ok_q <= 1'b0;
			fwd_idx_q     <= '0;
			fwd_circ_q    <= '0;
			fwd_node_q    <= '0;
			rev_found_q   <= 1'b0;
			rev_circ_q    <= '0;
			rev_node_q    <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			m_tvalid_q    <= 1'b0;
			act_q         <= ACT_NEXT;
			oc_q          <= '0;
			od_q          <= '0;
			os_q          <= '0;
		end else begin
			chk_q     <= (state_q == ST_SCAN);
			chk_idx_q <= cnt_q;

			// The result leaves on a transfer unless a new one is loaded.
			if (m_tvalid_q && m_tready && !finish) begin
				m_tvalid_q <= 1'b0;
			end

			// Keep the lowest slot for each kind of hit.
			if (chk_q) begin
				if (cmp_res.prev_hit && !fwd_found_q) begin
					fwd_found_q   <= 1'b1;
					fwd_node_ok_q <= cmp_res.node_ok;
					fwd_idx_q     <= chk_idx_q;
					fwd_circ_q    <= rd_data.next_circ;
					fwd_node_q    <= rd_data.next_node;
				end
				if (cmp_res.next_hit && !rev_found_q) begin
					rev_found_q <= 1'b1;
					rev_circ_q  <= rd_data.prev_circ;
					rev_node_q  <= rd_data.prev_node;
				end
				if (cmp_res.free && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= chk_idx_q;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q       <= s_tuser;
						circ_q       <= s_tdata[15:0];
						src_q        <= s_tdata[31:16];
						ncirc_q      <= s_tdata[47:32];
						nnode_q      <= s_tdata[63:48];
						fwd_found_q  <= 1'b0;
						rev_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						cnt_q        <= '0;
						if (s_tuser != KIND_UNUSED) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (cnt_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						act_q      <= res_act;
						oc_q       <= res_c;
						od_q       <= res_d;
						os_q       <= res_s;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = act_q;
	assign m_tdata  = {os_q, od_q, oc_q};

endmodule

// File: sv/circuit_label_swap_table_core.sv
// Top level of the circuit label swap table: register port, sequencer, compare unit, store.
//
//  Channel   Direction  Signals                         Content
//  s_*       in         tvalid tready tdata tuser        one cell or table command
//  m_*       out        tvalid tready tdata tuser        one rewritten header and action
//  APB       in/out     psel penable pwrite paddr ...    own_node_id at byte address 0
//
// Each item of kinds 0 to 2 scans every table slot, one slot per cycle through a single
// compare unit fed from the table memory's read port; the input is not ready again
// until the result has been loaded into the output register. A kind 3 item is taken
// from the input without a scan and gives no result.
// A result waits in the output register; a stalled output holds the finishing step.
// Reset clears every slot's valid flag at once and own_node_id to zero.
module circuit_label_swap_table_core #(
	parameter int TABLE_ENTRIES = cls_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // circ_id, src_node, new_circ_id, new_node
	input  logic [1:0]  s_tuser,   // kind
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_circ_id, out_dest_node, out_src_node
	output logic [2:0]  m_tuser,   // action
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cls_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic REG_OWN_NODE = 1'b0;

	logic [ID_W-1:0]  own_node_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	logic [IDX_W-1:0] chk_idx;
	logic             chk_valid;
	cmp_res_t         cmp_res;
	logic [ID_W-1:0]  key_circ;
	logic [ID_W-1:0]  key_src;
	logic             wr_en;
	logic             clr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	// Register port: one register, selected by the word address bit.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OWN_NODE)) begin
			own_node_q <= pwdata[ID_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_OWN_NODE) ? {{(32 - ID_W){1'b0}}, own_node_q} : '0;

	cls_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.own_node_id (own_node_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.chk_idx     (chk_idx),
		.cmp_res     (cmp_res),
		.key_circ    (key_circ),
		.key_src     (key_src),
		.wr_en       (wr_en),
		.clr_en      (clr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	cls_cmp u_cmp (
		.entry       (rd_data),
		.entry_valid (chk_valid),
		.key_circ    (key_circ),
		.key_src     (key_src),
		.res         (cmp_res)
	);

	cls_store #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.chk_idx   (chk_idx),
		.chk_valid (chk_valid),
		.wr_en     (wr_en),
		.clr_en    (clr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

endmodule

// File: sv/cls_checker.sv
// Port checker for the label swap table and its bind to the top level.
`include "circuit_label_swap_table_core_defines.svh"

module cls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import cls_pkg::*;

	// A stalled result stays put until its transfer.
	`CLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// A real command keeps the block busy for its table scan.
	`CLS_ASSERT_NEXT(a_busy_scan, s_tvalid && s_tready && (s_tuser != KIND_UNUSED), !s_tready, "input ready again during a scan")

	// Insert results carry an all-zero header.
	`CLS_ASSERT_NOW(a_insert_zero, m_tvalid && ((m_tuser == ACT_INSERTED) || (m_tuser == ACT_FULL)), m_tdata == 48'd0, "insert result with a non-zero header")

	// An unknown destroy names no circuit and no destination.
	`CLS_ASSERT_NOW(a_unknown_zero, m_tvalid && (m_tuser == ACT_DESTROY_UNKNOWN), m_tdata[31:0] == 32'd0, "unknown destroy with circuit or destination set")

endmodule

bind circuit_label_swap_table_core cls_checker u_cls_checker (.*);
